// File: hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash package
// Shared widths, round constants, initial hash values, controller states,
// the controller-to-datapath command bundle and the SHA-256 mixing functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int WORD_W      = 32;
  localparam int BLOCK_WORDS = 16;
  localparam int HASH_WORDS  = 8;
  localparam int NUM_ROUNDS  = 64;

  localparam int WCNT_W = $clog2(BLOCK_WORDS);
  localparam int RCNT_W = $clog2(NUM_ROUNDS);
  localparam int ECNT_W = $clog2(HASH_WORDS);

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t ROUND_K [0:NUM_ROUNDS-1] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_HASH [0:HASH_WORDS-1] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic              load_word;
    logic              start_rounds;
    logic              do_round;
    logic [RCNT_W-1:0] round_idx;
    logic              update_chain;
    logic              emit_shift;
    logic [ECNT_W-1:0] emit_idx;
  } ctrl_cmd_t;

  function automatic word_t rotr(input word_t v, input int n);
    rotr = (v >> n) | (v << (WORD_W - n));
  endfunction

  function automatic word_t big_s0(input word_t v);
    big_s0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic word_t big_s1(input word_t v);
    big_s1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic word_t small_s0(input word_t v);
    small_s0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t small_s1(input word_t v);
    small_s1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

// File: hw/rtl/sha256_dp.sv
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Message schedule shift line, working variables with one round unit, and
// the chaining hash that is added into after each block and shifted out.
// ----------------------------------------------------------------------------
module sha256_dp import sha256_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  ctrl_cmd_t cmd,
  input  word_t     word_in,
  output word_t     digest_word
);

  word_t sched [0:BLOCK_WORDS-1];
  word_t wv    [0:HASH_WORDS-1];
  word_t chain [0:HASH_WORDS-1];

  word_t sched_new;
  word_t ch;
  word_t mj;
  word_t t1;
  word_t t2;

  // The window sched[0..15] always holds W[t..t+15] for the current round.
  assign sched_new = small_s1(sched[14]) + sched[9] + small_s0(sched[1]) + sched[0];

  assign ch = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
  assign mj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
  assign t1 = wv[7] + big_s1(wv[4]) + ch + ROUND_K[cmd.round_idx] + sched[0];
  assign t2 = big_s0(wv[0]) + mj;

  always_ff @(posedge clk) begin
    if (cmd.load_word || cmd.do_round) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[BLOCK_WORDS-1] <= cmd.load_word ? word_in : sched_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_rounds) begin
      wv <= chain;
    end else if (cmd.do_round) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

  // While the digest goes out, the chain rotates toward word 0 and the
  // initial values fill in behind, so it ends up reset after eight beats.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= INIT_HASH;
    end else if (cmd.update_chain) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        chain[i] <= chain[i] + wv[i];
      end
    end else if (cmd.emit_shift) begin
      for (int i = 0; i < HASH_WORDS - 1; i++) begin
        chain[i] <= chain[i+1];
      end
      chain[HASH_WORDS-1] <= INIT_HASH[cmd.emit_idx];
    end
  end

  assign digest_word = chain[0];

endmodule

// File: hw/rtl/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences word loading, the 64 rounds, the chain update and the digest
// output, and drives the datapath through a command bundle.
// ----------------------------------------------------------------------------
module sha256_ctrl import sha256_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_end,
  input  logic      out_free,
  output logic      in_ready,
  output ctrl_cmd_t cmd
);

  ctrl_state_t       state;
  ctrl_state_t       state_next;
  logic [WCNT_W-1:0] word_cnt;
  logic [RCNT_W-1:0] round_cnt;
  logic [ECNT_W-1:0] emit_cnt;
  logic              end_flag;
  logic              accept;
  logic              last_word;

  assign accept    = in_valid && in_ready;
  assign last_word = (word_cnt == WCNT_W'(BLOCK_WORDS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      word_cnt  <= '0;
      round_cnt <= '0;
      emit_cnt  <= '0;
      end_flag  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        word_cnt <= word_cnt + 1'b1;
      end
      if (accept && last_word) begin
        end_flag <= in_end;
      end
      if (cmd.do_round) begin
        round_cnt <= round_cnt + 1'b1;
      end
      if (cmd.emit_shift) begin
        emit_cnt <= emit_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && last_word) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (round_cnt == RCNT_W'(NUM_ROUNDS - 1)) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = end_flag ? ST_EMIT : ST_LOAD;
      end
      ST_EMIT: begin
        if (out_free && emit_cnt == ECNT_W'(HASH_WORDS - 1)) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    cmd.load_word    = 1'b0;
    cmd.start_rounds = 1'b0;
    cmd.do_round     = 1'b0;
    cmd.round_idx    = round_cnt;
    cmd.update_chain = 1'b0;
    cmd.emit_shift   = 1'b0;
    cmd.emit_idx     = emit_cnt;
    unique case (state)
      ST_LOAD: begin
        in_ready         = 1'b1;
        cmd.load_word    = in_valid;
        cmd.start_rounds = in_valid && last_word;
      end
      ST_ROUND: begin
        cmd.do_round = 1'b1;
      end
      ST_UPDATE: begin
        cmd.update_chain = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit_shift = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/sha256_block_hash.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash
// Hashes an already padded message given as 32-bit words, 16 per block, and
// returns the eight digest words after the block whose last word is marked.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          handshake
//  s_*      in   tdata = message word, tlast = end  one beat per word
//  m_*      out  tdata = digest word, tlast = H7    eight beats per message
//
//  Each block is loaded as 16 words, one word per cycle while s_tvalid is high,
//  then runs 64 rounds through the single round unit and is added into the chain.
//  A marked final block then sends eight digest beats, one per cycle when
//  m_tready stays high. s_tready is low from the 16th word until that is done.
//  Reset restores the initial hash values at once; no clearing pass is needed.
//  A stalled output holds its beat in the output register.
// ----------------------------------------------------------------------------
module sha256_block_hash import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] message_word
  input  logic        s_tlast,   // message_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic        m_tlast    // digest_last
);

  ctrl_cmd_t cmd;
  word_t     digest_word;
  logic      out_free;

  assign out_free = !m_tvalid || m_tready;

  sha256_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_end   (s_tlast),
    .out_free (out_free),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .word_in     (s_tdata),
    .digest_word (digest_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_shift) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_shift) begin
      m_tdata <= digest_word;
      m_tlast <= (cmd.emit_idx == ECNT_W'(HASH_WORDS - 1));
    end
  end

`ifndef ASSERT_OFF
  // A digest beat is only loaded into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_shift |-> (!m_tvalid || m_tready))
    else $error("digest beat loaded over an untaken beat");

  // Input is held off while the digest goes out.
  a_no_input_in_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_shift |-> !s_tready)
    else $error("input ready during digest output");

  // The last digest beat hands control back to word loading.
  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_shift && cmd.emit_idx == ECNT_W'(HASH_WORDS - 1)) |=> s_tready)
    else $error("input not ready after last digest beat");

  // Rounds start only together with an accepted word.
  a_start_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.start_rounds |-> (s_tvalid && s_tready))
    else $error("rounds started without an accepted word");
`endif

endmodule
